// File: src/hcrc_pkg.sv
// Package with the shared types, codes and the CRC-8 byte fold of the response checker.
`default_nettype none

package hcrc_pkg;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned PHASE_W  = 2;

  localparam logic [BYTE_W-1:0] CRC_POLY      = 8'h8C;
  localparam logic [BYTE_W-1:0] HS_REPLY_RST  = 8'h43;

  localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_BUSY    = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_CRC_BAD = 2'd2;

  localparam logic [PHASE_W-1:0] PH_IDLE = 2'd0;
  localparam logic [PHASE_W-1:0] PH_HS2  = 2'd1;
  localparam logic [PHASE_W-1:0] PH_DATA = 2'd2;

  typedef struct packed {
    logic [BYTE_W-1:0] rx_byte;
    logic              exchange_start;
    logic              last_byte;
  } item_t;

  // Reflected CRC-8, one byte folded in, LSB first.
  function automatic logic [BYTE_W-1:0] crc8_fold(input logic [BYTE_W-1:0] acc,
                                                  input logic [BYTE_W-1:0] data);
    logic [BYTE_W-1:0] v;
    v = acc ^ data;
    for (int k = 0; k < BYTE_W; k++) begin
      v = v[0] ? ((v >> 1) ^ CRC_POLY) : (v >> 1);
    end
    return v;
  endfunction

endpackage

`default_nettype wire

// File: src/hcrc_ifs.sv
// Valid/ready channel interfaces for the input, result and configuration words.
`default_nettype none

interface hcrc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       exchange_start;
  logic       last_byte;

  modport source (output valid, output rx_byte, output exchange_start, output last_byte,
                  input ready);
  modport sink   (input valid, input rx_byte, input exchange_start, input last_byte,
                  output ready);
endinterface

interface hcrc_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [7:0] computed_crc;

  modport source (output valid, output status, output computed_crc, input ready);
  modport sink   (input valid, input status, input computed_crc, output ready);
endinterface

interface hcrc_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: src/handshake_crc8_response_checker_top.sv
// Top level of the handshake and CRC-8 response checker.
//
// Takes one received byte per cycle, back to back, and returns at most one word per byte:
// a status (ok, handshake busy, CRC mismatch) and the CRC computed over the data bytes.
// A byte passes an input register and then a result register before its result is offered;
// the CRC-8 fold (reflected, polynomial 0x8C) is an XOR network from the input register to
// the CRC accumulator. The input side keeps accepting while a result waits to be taken and
// stalls only when both registers are full. The handshake reply register resets to 0x43
// and is written through the cfg channel, which is always ready.
`default_nettype none

module handshake_crc8_response_checker_top (
  input  wire logic  clk,
  input  wire logic  rst_n,
  hcrc_in_if.sink    in_ch,
  hcrc_out_if.source out_ch,
  hcrc_cfg_if.sink   cfg_ch
);
  import hcrc_pkg::*;

  logic              in_valid_r;
  item_t             item_r;
  logic              item_take;
  logic [BYTE_W-1:0] hs_reply_r;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hs_reply_r <= HS_REPLY_RST;
    end else if (cfg_ch.valid) begin
      hs_reply_r <= cfg_ch.data;
    end
  end

  // Input register: refills in the cycle its word moves on.
  assign in_ch.ready = !in_valid_r || item_take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      item_r.rx_byte        <= in_ch.rx_byte;
      item_r.exchange_start <= in_ch.exchange_start;
      item_r.last_byte      <= in_ch.last_byte;
    end
  end

  hcrc_check u_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .hs_reply   (hs_reply_r),
    .item_valid (in_valid_r),
    .item       (item_r),
    .item_take  (item_take),
    .res_valid  (out_ch.valid),
    .res_ready  (out_ch.ready),
    .res_status (out_ch.status),
    .res_crc    (out_ch.computed_crc)
  );

endmodule

`default_nettype wire

// File: src/hcrc_check.sv
// Exchange tracking, CRC accumulation and the result register of the response checker.
`default_nettype none

module hcrc_check (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic [hcrc_pkg::BYTE_W-1:0]  hs_reply,
  input  wire logic                         item_valid,
  input  wire hcrc_pkg::item_t              item,
  output logic                              item_take,
  output logic                              res_valid,
  input  wire logic                         res_ready,
  output logic [hcrc_pkg::STATUS_W-1:0]     res_status,
  output logic [hcrc_pkg::BYTE_W-1:0]       res_crc
);
  import hcrc_pkg::*;

  logic [PHASE_W-1:0]  phase_r, phase_nxt;
  logic                matched_r, matched_nxt;
  logic [BYTE_W-1:0]   crc_r, crc_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0] status_r;
  logic [BYTE_W-1:0]   ocrc_r;

  logic                emit;
  logic [STATUS_W-1:0] emit_status;
  logic [BYTE_W-1:0]   emit_crc;

  // The result register frees up in the same cycle it is taken.
  assign item_take = item_valid && (!out_valid_r || res_ready);

  always_comb begin
    phase_nxt   = phase_r;
    matched_nxt = matched_r;
    crc_nxt     = crc_r;
    emit        = 1'b0;
    emit_status = STATUS_OK;
    emit_crc    = '0;
    if (item_take) begin
      if (item.exchange_start) begin
        matched_nxt = (item.rx_byte == hs_reply);
        crc_nxt     = '0;
        if (item.last_byte) begin
          phase_nxt   = PH_IDLE;
          emit        = 1'b1;
          emit_status = matched_nxt ? STATUS_OK : STATUS_BUSY;
        end else begin
          phase_nxt = PH_HS2;
        end
      end else begin
        unique case (phase_r)
          PH_HS2: begin
            if (!matched_r) begin
              phase_nxt   = PH_IDLE;
              emit        = 1'b1;
              emit_status = STATUS_BUSY;
            end else if (item.last_byte) begin
              phase_nxt = PH_IDLE;
              emit      = 1'b1;
            end else begin
              phase_nxt = PH_DATA;
            end
          end
          PH_DATA: begin
            if (item.last_byte) begin
              phase_nxt   = PH_IDLE;
              emit        = 1'b1;
              emit_status = (crc_r == item.rx_byte) ? STATUS_OK : STATUS_CRC_BAD;
              emit_crc    = crc_r;
            end else begin
              crc_nxt = crc8_fold(crc_r, item.rx_byte);
            end
          end
          default: begin
            phase_nxt = PH_IDLE;
          end
        endcase
      end
    end
  end

  always_comb begin
    if (item_take && emit) begin
      out_valid_nxt = 1'b1;
    end else if (res_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      matched_r   <= 1'b0;
      crc_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      matched_r   <= matched_nxt;
      crc_r       <= crc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (item_take && emit) begin
      status_r <= emit_status;
      ocrc_r   <= emit_crc;
    end
  end

  assign res_valid  = out_valid_r;
  assign res_status = status_r;
  assign res_crc    = ocrc_r;

endmodule

`default_nettype wire

// File: sim/tb_top.sv
// Self-checking testbench for the handshake and CRC-8 response checker.
`timescale 1ns / 1ps

module tb_top;
  import hcrc_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 16;
  localparam int PHASE_WORDS  = 267;
  localparam int NUM_PHASES   = 6;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [BYTE_W-1:0]   crc;
  } verdict_t;

  logic clk;
  logic rst_n;

  hcrc_in_if  in_if ();
  hcrc_out_if out_if ();
  hcrc_cfg_if cfg_if ();

  handshake_crc8_response_checker_top i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if),
    .cfg_ch (cfg_if)
  );

  item_t    rx_bytes_to_send[$];
  verdict_t verdicts_owed[$];
  item_t    drv_word;
  verdict_t seen_verdict;
  verdict_t owed_verdict;
  logic     verdict_fires;

  int       words_queued;
  int       words_accepted;
  int       phase_words;
  int       error_count;
  int       cycle_count;
  int       send_idle_pct;
  int       recv_idle_pct;
  bit       in_taken;

  // Shadow of the checker's state and of the reply register.
  logic [BYTE_W-1:0]  model_reply;
  logic [PHASE_W-1:0] model_phase;
  logic               model_hs_ok;
  logic [BYTE_W-1:0]  model_crc;

  // Bit-serial form of the reflected CRC-8, data taken LSB first.
  function automatic logic [BYTE_W-1:0] crc8_maxim_byte(input logic [BYTE_W-1:0] acc,
                                                        input logic [BYTE_W-1:0] data);
    logic [BYTE_W-1:0] r;
    logic              fb;
    r = acc;
    for (int i = 0; i < BYTE_W; i++) begin
      fb = r[0] ^ data[i];
      r  = r >> 1;
      if (fb) begin
        r = r ^ CRC_POLY;
      end
    end
    return r;
  endfunction

  function automatic void checker_verdict(input item_t w, output logic fires,
                                          output verdict_t v);
    fires    = 1'b0;
    v.status = STATUS_OK;
    v.crc    = 8'h00;
    if (w.exchange_start) begin
      model_hs_ok = (w.rx_byte == model_reply);
      model_crc   = 8'h00;
      if (w.last_byte) begin
        model_phase = PH_IDLE;
        fires       = 1'b1;
        v.status    = model_hs_ok ? STATUS_OK : STATUS_BUSY;
      end else begin
        model_phase = PH_HS2;
      end
    end else if (model_phase == PH_HS2) begin
      if (!model_hs_ok) begin
        model_phase = PH_IDLE;
        fires       = 1'b1;
        v.status    = STATUS_BUSY;
      end else if (w.last_byte) begin
        model_phase = PH_IDLE;
        fires       = 1'b1;
      end else begin
        model_phase = PH_DATA;
      end
    end else if (model_phase == PH_DATA) begin
      if (w.last_byte) begin
        model_phase = PH_IDLE;
        fires       = 1'b1;
        v.status    = (model_crc == w.rx_byte) ? STATUS_OK : STATUS_CRC_BAD;
        v.crc       = model_crc;
      end else begin
        model_crc = crc8_maxim_byte(model_crc, w.rx_byte);
      end
    end else begin
      model_phase = PH_IDLE;
    end
  endfunction

  task automatic report_mismatch(input string msg);
    error_count++;
    $display("tb_top: mismatch at cycle %0d: %s", cycle_count, msg);
  endtask

  task automatic queue_word(input logic [BYTE_W-1:0] b, input logic s, input logic l);
    item_t w;
    w.rx_byte        = b;
    w.exchange_start = s;
    w.last_byte      = l;
    rx_bytes_to_send.push_back(w);
    words_queued++;
  endtask

  // One exchange, mostly well formed; some end early, lose their trailer or carry a bad one.
  task automatic queue_exchange(input logic [BYTE_W-1:0] reply);
    logic [BYTE_W-1:0] first;
    logic [BYTE_W-1:0] data;
    logic [BYTE_W-1:0] crc;
    int                kind;
    int                n;
    bit                matched;
    matched = ($urandom_range(0, 99) < 85);
    kind    = $urandom_range(0, 99);
    if (matched) begin
      first = reply;
    end else if ($urandom_range(0, 1) == 0) begin
      first = reply ^ (8'h01 << $urandom_range(0, 7));
    end else begin
      first = 8'($urandom_range(0, 255));
      if (first == reply) begin
        first = ~reply;
      end
    end
    if (kind < 5) begin
      queue_word(first, 1'b1, 1'b1);
      phase_words += 1;
      return;
    end
    queue_word(first, 1'b1, 1'b0);
    if (kind < 12) begin
      queue_word(8'($urandom_range(0, 255)), 1'b0, 1'b1);
      phase_words += 2;
      return;
    end
    queue_word(8'($urandom_range(0, 255)), 1'b0, 1'b0);
    phase_words += 2;
    if (!matched) begin
      // The block drops these after the busy report.
      repeat ($urandom_range(0, 3)) begin
        queue_word(8'($urandom_range(0, 255)), 1'b0, 1'($urandom_range(0, 1)));
      end
      return;
    end
    n   = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 24) : $urandom_range(0, 6);
    crc = 8'h00;
    repeat (n) begin
      data = 8'($urandom_range(0, 255));
      queue_word(data, 1'b0, 1'b0);
      crc = crc8_maxim_byte(crc, data);
    end
    phase_words += n;
    if (kind < 17) begin
      return;
    end
    queue_word(($urandom_range(0, 99) < 70) ? crc : 8'($urandom_range(0, 255)), 1'b0, 1'b1);
    phase_words += 1;
  endtask

  task automatic wait_idle();
    do begin
      @(negedge clk);
    end while (words_accepted != words_queued || verdicts_owed.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reply(input logic [BYTE_W-1:0] value);
    @(negedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= value;
    do begin
      @(posedge clk);
    end while (!cfg_if.ready);
    @(negedge clk);
    cfg_if.valid <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    clk            = 1'b0;
    rst_n          = 1'b0;
    in_if.valid    = 1'b0;
    in_if.rx_byte  = 8'h00;
    in_if.exchange_start = 1'b0;
    in_if.last_byte      = 1'b0;
    out_if.ready   = 1'b0;
    cfg_if.valid   = 1'b0;
    cfg_if.data    = 8'h00;
    forever #1 clk = ~clk;
  end

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
  end

  // Sender side: a word is held until it is taken, then the next one may follow.
  always @(negedge clk) begin
    if (rst_n && (!in_if.valid || in_taken)) begin
      if (rx_bytes_to_send.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        drv_word              = rx_bytes_to_send.pop_front();
        in_if.valid          <= 1'b1;
        in_if.rx_byte        <= drv_word.rx_byte;
        in_if.exchange_start <= drv_word.exchange_start;
        in_if.last_byte      <= drv_word.last_byte;
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    out_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end else begin
      in_taken = 1'b0;
      if (!rst_n) begin
        model_reply = HS_REPLY_RST;
        model_phase = PH_IDLE;
        model_hs_ok = 1'b0;
        model_crc   = 8'h00;
      end else begin
        if (cfg_if.valid && cfg_if.ready) begin
          model_reply = cfg_if.data;
        end
        if (in_if.valid && in_if.ready) begin
          in_taken = 1'b1;
          words_accepted++;
          drv_word.rx_byte        = in_if.rx_byte;
          drv_word.exchange_start = in_if.exchange_start;
          drv_word.last_byte      = in_if.last_byte;
          checker_verdict(drv_word, verdict_fires, owed_verdict);
          if (verdict_fires) begin
            verdicts_owed.push_back(owed_verdict);
          end
        end
        if (out_if.valid && out_if.ready) begin
          seen_verdict.status = out_if.status;
          seen_verdict.crc    = out_if.computed_crc;
          if (verdicts_owed.size() == 0) begin
            report_mismatch($sformatf("unexpected word status %0d crc %02h",
                                      seen_verdict.status, seen_verdict.crc));
          end else begin
            owed_verdict = verdicts_owed.pop_front();
            if (seen_verdict.status !== owed_verdict.status ||
                seen_verdict.crc !== owed_verdict.crc) begin
              report_mismatch($sformatf("status %0d crc %02h, wanted status %0d crc %02h",
                                        seen_verdict.status, seen_verdict.crc,
                                        owed_verdict.status, owed_verdict.crc));
            end
          end
        end
      end
    end
  end

  initial begin
    words_queued   = 0;
    words_accepted = 0;
    error_count    = 0;
    cycle_count    = 0;
    send_idle_pct  = 19;
    recv_idle_pct  = 51;
    @(posedge rst_n);
    @(posedge clk);

    // Directed part, reply register still at its reset value.
    queue_word(HS_REPLY_RST, 1'b1, 1'b1);
    queue_word(8'h42, 1'b1, 1'b1);
    queue_word(HS_REPLY_RST, 1'b1, 1'b0);
    queue_word(8'hFF, 1'b0, 1'b1);
    // Wrong reply gives busy on the second byte; what follows is dropped.
    queue_word(8'h00, 1'b1, 1'b0);
    queue_word(8'h00, 1'b0, 1'b0);
    queue_word(8'hAA, 1'b0, 1'b1);
    queue_word(8'h55, 1'b0, 1'b0);
    // No data bytes at all, so the trailer is checked against zero.
    queue_word(HS_REPLY_RST, 1'b1, 1'b0);
    queue_word(8'h00, 1'b0, 1'b0);
    queue_word(8'h00, 1'b0, 1'b1);
    queue_word(HS_REPLY_RST, 1'b1, 1'b0);
    queue_word(8'h01, 1'b0, 1'b0);
    queue_word(8'h00, 1'b0, 1'b0);
    queue_word(8'hFF, 1'b0, 1'b0);
    queue_word(crc8_maxim_byte(crc8_maxim_byte(8'h00, 8'h00), 8'hFF), 1'b0, 1'b1);
    queue_word(HS_REPLY_RST, 1'b1, 1'b0);
    queue_word(8'h80, 1'b0, 1'b0);
    queue_word(8'h80, 1'b0, 1'b0);
    queue_word(~crc8_maxim_byte(8'h00, 8'h80), 1'b0, 1'b1);
    // A start in the middle of the data restarts; this one is also the last byte.
    queue_word(HS_REPLY_RST, 1'b1, 1'b0);
    queue_word(8'h7E, 1'b0, 1'b0);
    queue_word(8'h12, 1'b0, 1'b0);
    queue_word(HS_REPLY_RST, 1'b1, 1'b1);
    // A start while the second handshake byte is awaited.
    queue_word(HS_REPLY_RST, 1'b1, 1'b0);
    queue_word(8'h42, 1'b1, 1'b0);
    queue_word(8'h00, 1'b0, 1'b0);

    for (int p = 0; p < NUM_PHASES; p++) begin
      logic [BYTE_W-1:0] reply;
      wait_idle();
      case (p / 2)
        0: begin
          send_idle_pct = 19;
          recv_idle_pct = 51;
        end
        1: begin
          send_idle_pct = 51;
          recv_idle_pct = 19;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      if (p == 0) begin
        reply = 8'h00;
      end else if (p == 1) begin
        reply = 8'hFF;
      end else begin
        reply = 8'($urandom_range(0, 255));
      end
      write_reply(reply);
      phase_words = 0;
      while (phase_words < PHASE_WORDS) begin
        if ($urandom_range(0, 99) < 6) begin
          queue_word(8'($urandom_range(0, 255)), 1'b0, 1'($urandom_range(0, 1)));
        end
        queue_exchange(reply);
      end
    end

    wait_idle();
    if (error_count == 0 && verdicts_owed.size() == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
